[hw/rtl/imu_serial_frame_parser_defines.svh]
// assertion macros shared by the serial frame parser rtl
`ifndef IMU_SERIAL_FRAME_PARSER_DEFINES_SVH
`define IMU_SERIAL_FRAME_PARSER_DEFINES_SVH

// same-cycle implication, clocked on clk and disabled while arst_n is low
`define ISFP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("serial frame parser check failed");

// next-cycle implication, clocked on clk and disabled while arst_n is low
`define ISFP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("serial frame parser check failed");

`endif

[hw/rtl/imu_sfp_pkg.sv]
// shared constants and types for the serial frame parser
package imu_sfp_pkg;

	localparam int NUM_RECORD_TYPES = 11;
	localparam int REC_AW = (NUM_RECORD_TYPES > 1) ? $clog2(NUM_RECORD_TYPES) : 1;
	localparam int IDX_W = 4;
	localparam int CNT_W = 4;

	localparam logic [7:0] SYNC_BYTE = 8'h55;
	localparam logic [7:0] FIRST_TYPE = 8'h50;
	localparam logic [CNT_W-1:0] POS_SYNC = 4'd0;
	localparam logic [CNT_W-1:0] POS_TYPE = 4'd1;
	localparam logic [CNT_W-1:0] POS_CHECK = 4'd10;

	localparam logic ACT_RX = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef struct packed {
		logic done;
		logic ok;
		logic [7:0] ftype;
		logic [63:0] payload;
	} frame_t;

endpackage

[hw/rtl/imu_serial_frame_parser.sv]
// Serial frame parser for 11-byte sensor frames: takes one word per cycle while in_stall
// is low (a received byte or a record read), one result per word. A word is captured in
// an input register; the frame counter, mod-256 running sum and record store are updated as
// it moves into the result register, from which its result word shows, so the sustained rate
// is one word per clock, limited only by out_stall. The record store is eleven 64-bit
// registers cleared directly by reset, so the block is ready right after reset.
`include "imu_serial_frame_parser_defines.svh"

module imu_serial_frame_parser (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic action,
	input logic [7:0] rx_byte,
	input logic [imu_sfp_pkg::IDX_W-1:0] record_index,
	output logic out_valid,
	input logic out_stall,
	output logic frame_accepted,
	output logic checksum_error,
	output logic [7:0] frame_type,
	output logic [63:0] frame_payload,
	output logic [63:0] read_data
);

	logic valid_s1;
	logic action_s1;
	logic [7:0] rx_byte_s1;
	logic [imu_sfp_pkg::IDX_W-1:0] record_index_s1;

	logic out_valid_q;
	logic accepted_q;
	logic cksum_err_q;
	logic [7:0] type_q;
	logic [63:0] payload_q;
	logic [63:0] read_q;

	logic advance;
	logic process;
	logic take_in;
	logic byte_en;
	logic [63:0] rd_data;
	imu_sfp_pkg::frame_t frame;

	// stage 1 moves on when the result register is empty or being drained
	assign advance = !out_valid_q || !out_stall;
	assign process = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign take_in = in_valid && !in_stall;
	assign byte_en = process && (action_s1 == imu_sfp_pkg::ACT_RX);

	imu_sfp_framer u_framer (
		.clk(clk),
		.arst_n(arst_n),
		.byte_en(byte_en),
		.rx_byte(rx_byte_s1),
		.frame(frame)
	);

	imu_sfp_store u_store (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(frame.done && frame.ok),
		.wr_type(frame.ftype),
		.wr_data(frame.payload),
		.rd_idx(record_index_s1),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take_in || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			action_s1 <= action;
			rx_byte_s1 <= rx_byte;
			record_index_s1 <= record_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= process || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			accepted_q <= frame.done && frame.ok;
			cksum_err_q <= frame.done && !frame.ok;
			type_q <= frame.ftype;
			payload_q <= frame.payload;
			read_q <= (action_s1 == imu_sfp_pkg::ACT_READ) ? rd_data : 64'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_accepted = accepted_q;
	assign checksum_error = cksum_err_q;
	assign frame_type = type_q;
	assign frame_payload = payload_q;
	assign read_data = read_q;

	// a read word never reports a frame
	`ISFP_ASSERT_NEXT(a_read_no_frame, process && (action_s1 == imu_sfp_pkg::ACT_READ),
		out_valid && !frame_accepted && !checksum_error)
	// a blocked stage 1 word stays put
	`ISFP_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1)
	// an accepted word always lands in stage 1
	`ISFP_ASSERT_NEXT(a_take_lands, take_in, valid_s1)
	// accepted and error flags are exclusive on a shown result
	`ISFP_ASSERT_NOW(a_flags_excl, out_valid_q, !(accepted_q && cksum_err_q))

endmodule

[hw/rtl/imu_sfp_framer.sv]
// frame collector: byte counter, running sum, type byte and payload shifter
module imu_sfp_framer (
	input logic clk,
	input logic arst_n,
	input logic byte_en,
	input logic [7:0] rx_byte,
	output imu_sfp_pkg::frame_t frame
);

	logic [imu_sfp_pkg::CNT_W-1:0] count_q, count_n;
	logic [7:0] type_q, type_n;
	logic [63:0] shift_q, shift_n;
	logic [7:0] sum_q, sum_n;

	always_comb begin
		frame = '0;
		count_n = count_q;
		type_n = type_q;
		shift_n = shift_q;
		sum_n = sum_q;
		if (byte_en) begin
			if (count_q == imu_sfp_pkg::POS_SYNC) begin
				// anything but the sync byte is dropped here
				if (rx_byte == imu_sfp_pkg::SYNC_BYTE) begin
					sum_n = rx_byte;
					shift_n = '0;
					count_n = imu_sfp_pkg::POS_TYPE;
				end
			end else if (count_q == imu_sfp_pkg::POS_TYPE) begin
				type_n = rx_byte;
				sum_n = sum_q + rx_byte;
				count_n = count_q + imu_sfp_pkg::CNT_W'(1);
			end else if (count_q < imu_sfp_pkg::POS_CHECK) begin
				shift_n = {rx_byte, shift_q[63:8]};
				sum_n = sum_q + rx_byte;
				count_n = count_q + imu_sfp_pkg::CNT_W'(1);
			end else begin
				// checksum byte, also taken for any count past it
				count_n = imu_sfp_pkg::POS_SYNC;
				frame.done = 1'b1;
				frame.ok = (sum_q == rx_byte);
				frame.ftype = type_q;
				frame.payload = shift_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= imu_sfp_pkg::POS_SYNC;
			type_q <= '0;
			shift_q <= '0;
			sum_q <= '0;
		end else begin
			count_q <= count_n;
			type_q <= type_n;
			shift_q <= shift_n;
			sum_q <= sum_n;
		end
	end

endmodule

[hw/rtl/imu_sfp_store.sv]
// record store: one payload per record type, cleared at reset
module imu_sfp_store (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [7:0] wr_type,
	input logic [63:0] wr_data,
	input logic [imu_sfp_pkg::IDX_W-1:0] rd_idx,
	output logic [63:0] rd_data
);

	logic [63:0] rec_q [imu_sfp_pkg::NUM_RECORD_TYPES];
	logic [7:0] wr_off;
	logic wr_hit;
	logic rd_ok;

	assign wr_off = wr_type - imu_sfp_pkg::FIRST_TYPE;
	assign wr_hit = wr_en && (wr_type >= imu_sfp_pkg::FIRST_TYPE)
		&& ({1'b0, wr_off} < 9'(imu_sfp_pkg::NUM_RECORD_TYPES));
	assign rd_ok = {1'b0, rd_idx}
		< (imu_sfp_pkg::IDX_W + 1)'(imu_sfp_pkg::NUM_RECORD_TYPES);

	always_comb begin
		rd_data = '0;
		if (rd_ok) begin
			rd_data = rec_q[rd_idx[imu_sfp_pkg::REC_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < imu_sfp_pkg::NUM_RECORD_TYPES; i++) begin
				rec_q[i] <= '0;
			end
		end else if (wr_hit) begin
			rec_q[wr_off[imu_sfp_pkg::REC_AW-1:0]] <= wr_data;
		end
	end

endmodule

[dv/imu_serial_frame_parser_checker.sv]
`timescale 1ns / 1ps
// predicts and checks every result word of the serial frame parser
module imu_serial_frame_parser_checker
	import imu_sfp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic action,
	input logic [7:0] rx_byte,
	input logic [IDX_W-1:0] record_index,
	input logic out_valid,
	input logic out_stall,
	input logic frame_accepted,
	input logic checksum_error,
	input logic [7:0] frame_type,
	input logic [63:0] frame_payload,
	input logic [63:0] read_data,
	output int unsigned n_errors,
	output int unsigned results_due
);

	typedef struct packed {
		logic accepted;
		logic bad_sum;
		logic [7:0] ftype;
		logic [63:0] payload;
		logic [63:0] rdata;
	} parse_result_t;

	parse_result_t parse_results[$];
	parse_result_t want;
	int unsigned err_cnt = 0;

	// shadow of the frame collector and record store
	logic [CNT_W-1:0] frame_pos;
	logic [7:0] cur_type;
	logic [63:0] payload_sr;
	logic [7:0] run_sum;
	logic [63:0] records [NUM_RECORD_TYPES];

	function automatic parse_result_t parse_word(input logic act, input logic [7:0] b,
		input logic [IDX_W-1:0] idx);
		parse_result_t r;
		r = '0;
		if (act == ACT_READ) begin
			if (idx < NUM_RECORD_TYPES)
				r.rdata = records[idx];
			return r;
		end
		if (frame_pos == POS_SYNC) begin
			// anything but sync is dropped while hunting
			if (b == SYNC_BYTE) begin
				run_sum = b;
				payload_sr = '0;
				frame_pos = POS_TYPE;
			end
		end else if (frame_pos == POS_TYPE) begin
			cur_type = b;
			run_sum = run_sum + b;
			frame_pos = frame_pos + 1'b1;
		end else if (frame_pos < POS_CHECK) begin
			payload_sr = {b, payload_sr[63:8]};
			run_sum = run_sum + b;
			frame_pos = frame_pos + 1'b1;
		end else begin
			frame_pos = POS_SYNC;
			r.ftype = cur_type;
			r.payload = payload_sr;
			if (run_sum == b) begin
				r.accepted = 1'b1;
				if (cur_type >= FIRST_TYPE && cur_type - FIRST_TYPE < NUM_RECORD_TYPES)
					records[cur_type - FIRST_TYPE] = payload_sr;
			end else begin
				r.bad_sum = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos = POS_SYNC;
			cur_type = '0;
			payload_sr = '0;
			run_sum = '0;
			foreach (records[i])
				records[i] = '0;
			parse_results.delete();
			n_errors <= 0;
			results_due <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (parse_results.size() == 0) begin
					$display("%0t: result word with nothing expected, expected none actual %b %b %h %h %h",
						$time, frame_accepted, checksum_error, frame_type, frame_payload,
						read_data);
					err_cnt++;
				end else begin
					want = parse_results.pop_front();
					check_field("frame_accepted", want.accepted, frame_accepted);
					check_field("checksum_error", want.bad_sum, checksum_error);
					check_field("frame_type", want.ftype, frame_type);
					check_field("frame_payload", want.payload, frame_payload);
					check_field("read_data", want.rdata, read_data);
				end
			end
			if (in_valid && !in_stall)
				parse_results.push_back(parse_word(action, rx_byte, record_index));
			n_errors <= err_cnt;
			results_due <= parse_results.size();
		end
	end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// testbench top for the serial frame parser: stimulus, receiver stalls and verdict
module tb;
	import imu_sfp_pkg::*;

	localparam int WORD_TARGET = 1400;
	localparam int LONG_HOLD_AT = 600;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum int {RX_FREE, RX_COIN, RX_EVERY4, RX_HEAVY} rx_mode_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = ACT_RX;
	logic [7:0] rx_byte = '0;
	logic [IDX_W-1:0] record_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic frame_accepted;
	logic checksum_error;
	logic [7:0] frame_type;
	logic [63:0] frame_payload;
	logic [63:0] read_data;
	int unsigned n_errors;
	int unsigned results_due;

	int burst_left = 0;
	int n_sent = 0;
	int unsigned cycle_cnt = 0;

	imu_serial_frame_parser u_top (.*);

	imu_serial_frame_parser_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// sender works in bursts; each call returns at the edge the word is taken
	task automatic send_word(input logic act, input logic [7:0] b, input logic [IDX_W-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		action <= act;
		rx_byte <= b;
		record_index <= idx;
		n_sent++;
		do @(posedge clk); while (in_stall);
	endtask

	// unused fields carry random values so every bit toggles
	task automatic send_byte(input logic [7:0] b);
		send_word(ACT_RX, b, $urandom_range(0, 15));
	endtask

	task automatic send_read(input logic [IDX_W-1:0] idx);
		send_word(ACT_READ, $urandom_range(0, 255), idx);
	endtask

	task automatic send_frame(input logic [7:0] ftype, input logic [63:0] payload,
		input bit corrupt, input int read_pct);
		logic [7:0] sum;
		sum = SYNC_BYTE + ftype;
		send_byte(SYNC_BYTE);
		send_byte(ftype);
		for (int i = 0; i < 8; i++) begin
			// reads in mid-frame must not disturb collection
			if ($urandom_range(0, 99) < read_pct)
				send_read($urandom_range(0, 15));
			send_byte(payload[8*i +: 8]);
			sum = sum + payload[8*i +: 8];
		end
		if (corrupt)
			sum = sum ^ 8'($urandom_range(1, 255));
		send_byte(sum);
	endtask

	// eleven non-sync bytes finish any open frame and leave the hunter idle
	task automatic flush_frame();
		logic [7:0] b;
		repeat (11) begin
			b = $urandom_range(0, 255);
			if (b == SYNC_BYTE)
				b = 8'h00;
			send_byte(b);
		end
	endtask

	initial begin
		int mode;
		int phase_left;
		int rx_cycles;
		phase_left = 0;
		rx_cycles = 0;
		mode = RX_FREE;
		wait (arst_n);
		forever begin
			@(posedge clk);
			rx_cycles++;
			if (phase_left == 0) begin
				mode = $urandom_range(RX_FREE, RX_HEAVY);
				phase_left = $urandom_range(16, 128);
			end
			phase_left--;
			if (rx_cycles >= LONG_HOLD_AT && rx_cycles < LONG_HOLD_AT + LONG_HOLD_CYCLES)
				out_stall <= 1'b1;
			else if (mode == RX_COIN)
				out_stall <= $urandom_range(0, 1);
			else if (mode == RX_EVERY4)
				out_stall <= (rx_cycles % 4 == 3);
			else if (mode == RX_HEAVY)
				out_stall <= ($urandom_range(0, 9) < 8);
			else
				out_stall <= 1'b0;
		end
	end

	initial begin
		int pick;
		logic [7:0] ftype;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// store is empty after reset, out-of-range index reads zero
		send_read(0);
		send_read(15);
		send_byte(8'h00);
		send_frame(FIRST_TYPE + NUM_RECORD_TYPES - 1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0);
		send_read(NUM_RECORD_TYPES - 1);
		// unstored type with a bad checksum
		send_frame(FIRST_TYPE + NUM_RECORD_TYPES, 64'h0, 1'b1, 0);

		while (n_sent < WORD_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				ftype = ($urandom_range(0, 9) < 7) ?
					FIRST_TYPE + $urandom_range(0, NUM_RECORD_TYPES - 1) : $urandom_range(0, 255);
				send_frame(ftype, {$urandom, $urandom}, $urandom_range(0, 99) < 15, 10);
			end else if (pick < 75) begin
				send_read($urandom_range(0, 15));
			end else if (pick < 87) begin
				repeat ($urandom_range(1, 4)) send_byte($urandom_range(0, 255));
				flush_frame();
			end else begin
				// truncated frame
				send_byte(SYNC_BYTE);
				repeat ($urandom_range(0, 9)) send_byte($urandom_range(0, 255));
				flush_frame();
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (n_errors == 0 && results_due == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
